>>> design/lmsm_pkg.sv
// ----------------------------------------------------------------------------
// lmsm_pkg
// Shared types and constants for the link matching controller
// ----------------------------------------------------------------------------
package lmsm_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int MAX_FX      = 3;
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
	localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

	// register index decoded from paddr[2]
	localparam logic REG_MAC_EN  = 1'b0;
	localparam logic REG_TIMEOUT = 1'b1;

	typedef enum logic [2:0] {
		ACT_START    = 3'd0,
		ACT_RESET    = 3'd1,
		ACT_TRIGGER  = 3'd2,
		ACT_CARR_UP  = 3'd3,
		ACT_CARR_DN  = 3'd4,
		ACT_LINK_LOST = 3'd5,
		ACT_TIMEOUT  = 3'd6,
		ACT_NEIGHBOR = 3'd7
	} act_t;

	typedef enum logic [1:0] {
		MODE_UNMATCHED = 2'd0,
		MODE_MATCHING  = 2'd1,
		MODE_MATCHED   = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		FX_NONE  = 3'd0,
		FX_STATE = 3'd1,
		FX_READY = 3'd2,
		FX_MAC   = 3'd3,
		FX_START = 3'd4,
		FX_STOP  = 3'd5
	} fx_kind_t;

	typedef struct packed {
		fx_kind_t kind;
		mode_t    pstate;
		logic     rdy;
	} fx_t;

	// one classified item: its effects in order plus the values after the event
	typedef struct packed {
		fx_t [MAX_FX-1:0] fx;
		logic [1:0]       count;
		logic [47:0]      mac;
		logic [15:0]      tmo;
		mode_t            state_now;
		logic             ready_now;
		logic [15:0]      ignored;
	} plan_t;

endpackage

>>> design/lmsm_front.sv
// ----------------------------------------------------------------------------
// lmsm_front
// Accepts events, runs the mode machine and builds the effect list per item
// ----------------------------------------------------------------------------
module lmsm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_valid,
	output logic                s_ready,
	input  lmsm_pkg::act_t      action,
	input  logic                carrier_present,
	input  logic [47:0]         neighbor_mac,
	input  logic                mac_present,
	input  logic                mac_publish_enable,
	input  logic [15:0]         detect_timeout_ms,
	input  logic                q_full,
	output logic                push,
	output lmsm_pkg::plan_t     push_plan
);

	lmsm_pkg::mode_t mode_q, last_pub_q;
	logic            pub_valid_q, ready_q, held_valid_q;
	logic [47:0]     held_mac_q;
	logic [15:0]     ign_q;

	lmsm_pkg::mode_t  mode_d, last_pub_d, target;
	logic             pub_valid_d, ready_d, held_valid_d;
	logic [47:0]      held_mac_d;
	logic [15:0]      ign_d;
	logic             do_stop, do_withdraw, do_enter, do_mac, handled;
	logic [1:0]       n;
	lmsm_pkg::fx_t [lmsm_pkg::MAX_FX-1:0] fx;

	assign s_ready = !q_full;
	assign push    = s_valid && s_ready;

	// event decode per mode
	always_comb begin
		do_stop     = 1'b0;
		do_withdraw = 1'b0;
		do_enter    = 1'b0;
		do_mac      = 1'b0;
		handled     = 1'b1;
		target      = lmsm_pkg::MODE_UNMATCHED;
		if (action == lmsm_pkg::ACT_START) begin
			do_enter = 1'b1;
		end else begin
			case (mode_q)
				lmsm_pkg::MODE_UNMATCHED: begin
					if (action == lmsm_pkg::ACT_TRIGGER) begin
						do_enter = 1'b1;
						target   = carrier_present ? lmsm_pkg::MODE_MATCHED
						                           : lmsm_pkg::MODE_MATCHING;
					end else if (action == lmsm_pkg::ACT_RESET) begin
						do_withdraw = 1'b1;
						do_enter    = 1'b1;
					end else begin
						handled = 1'b0;
					end
				end
				lmsm_pkg::MODE_MATCHING: begin
					if (action == lmsm_pkg::ACT_CARR_UP) begin
						do_stop  = 1'b1;
						do_enter = 1'b1;
						target   = lmsm_pkg::MODE_MATCHED;
					end else if (action == lmsm_pkg::ACT_TIMEOUT ||
					             action == lmsm_pkg::ACT_RESET) begin
						do_stop     = 1'b1;
						do_withdraw = 1'b1;
						do_enter    = 1'b1;
					end else begin
						handled = 1'b0;
					end
				end
				default: begin
					if (action == lmsm_pkg::ACT_CARR_DN || action == lmsm_pkg::ACT_LINK_LOST ||
					    action == lmsm_pkg::ACT_RESET) begin
						do_withdraw = 1'b1;
						do_enter    = 1'b1;
					end else if (action == lmsm_pkg::ACT_NEIGHBOR) begin
						do_mac = mac_publish_enable && mac_present &&
						         !(held_valid_q && held_mac_q == neighbor_mac);
					end else begin
						handled = 1'b0;
					end
				end
			endcase
		end
	end

	// effect list in order: exit, transition, entry
	always_comb begin
		mode_d       = mode_q;
		last_pub_d   = last_pub_q;
		pub_valid_d  = pub_valid_q;
		ready_d      = ready_q;
		held_valid_d = held_valid_q;
		held_mac_d   = held_mac_q;
		n            = 2'd0;
		for (int i = 0; i < lmsm_pkg::MAX_FX; i++) begin
			fx[i] = '{kind: lmsm_pkg::FX_NONE, pstate: lmsm_pkg::MODE_UNMATCHED, rdy: 1'b0};
		end
		if (do_stop) begin
			fx[n].kind = lmsm_pkg::FX_STOP;
			n = n + 2'd1;
		end
		if (do_withdraw && ready_q) begin
			ready_d    = 1'b0;
			fx[n].kind = lmsm_pkg::FX_READY;
			n = n + 2'd1;
		end
		if (do_enter) begin
			if (target != lmsm_pkg::MODE_MATCHED) begin
				held_valid_d = 1'b0;
				held_mac_d   = '0;
			end
			mode_d = target;
			if (!(pub_valid_q && last_pub_q == target)) begin
				pub_valid_d  = 1'b1;
				last_pub_d   = target;
				fx[n].kind   = lmsm_pkg::FX_STATE;
				fx[n].pstate = target;
				n = n + 2'd1;
			end
			if (target == lmsm_pkg::MODE_MATCHING) begin
				fx[n].kind = lmsm_pkg::FX_START;
				n = n + 2'd1;
			end
			if (target == lmsm_pkg::MODE_MATCHED) begin
				ready_d    = 1'b1;
				fx[n].kind = lmsm_pkg::FX_READY;
				fx[n].rdy  = 1'b1;
				n = n + 2'd1;
			end
		end
		if (do_mac) begin
			held_valid_d = 1'b1;
			held_mac_d   = neighbor_mac;
			fx[n].kind   = lmsm_pkg::FX_MAC;
			n = n + 2'd1;
		end
		if (n == 2'd0) begin
			n = 2'd1;
		end
	end

	assign ign_d = (!handled && ign_q != lmsm_pkg::COUNT_MAX) ? ign_q + 16'd1 : ign_q;

	always_comb begin
		push_plan.fx        = fx;
		push_plan.count     = n;
		push_plan.mac       = neighbor_mac;
		push_plan.tmo       = detect_timeout_ms;
		push_plan.state_now = mode_d;
		push_plan.ready_now = ready_d;
		push_plan.ignored   = ign_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= lmsm_pkg::MODE_UNMATCHED;
			last_pub_q   <= lmsm_pkg::MODE_UNMATCHED;
			pub_valid_q  <= 1'b0;
			ready_q      <= 1'b0;
			held_valid_q <= 1'b0;
			held_mac_q   <= '0;
			ign_q        <= '0;
		end else if (push) begin
			mode_q       <= mode_d;
			last_pub_q   <= last_pub_d;
			pub_valid_q  <= pub_valid_d;
			ready_q      <= ready_d;
			held_valid_q <= held_valid_d;
			held_mac_q   <= held_mac_d;
			ign_q        <= ign_d;
		end
	end

endmodule

>>> design/lmsm_queue.sv
// ----------------------------------------------------------------------------
// lmsm_queue
// Short queue of classified items between front and back
// ----------------------------------------------------------------------------
module lmsm_queue #(
	parameter int DEPTH = lmsm_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lmsm_pkg::plan_t push_plan,
	output logic            full,
	input  logic            pop,
	output lmsm_pkg::plan_t head,
	output logic            empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	lmsm_pkg::plan_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push, do_pop;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_plan;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

>>> design/lmsm_back.sv
// ----------------------------------------------------------------------------
// lmsm_back
// Walks the effect list of the head item, one result per cycle while the receiver is ready
// ----------------------------------------------------------------------------
module lmsm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  lmsm_pkg::plan_t head,
	input  logic            empty,
	output logic            pop,
	output logic            m_valid,
	input  logic            m_ready,
	output logic            last,
	output lmsm_pkg::fx_kind_t kind,
	output logic [85:0]     data
);

	logic [1:0]         idx_q;
	logic               valid_q, last_q, rdy_q, ready_now_q;
	lmsm_pkg::fx_kind_t kind_q;
	lmsm_pkg::mode_t    pstate_q, state_now_q;
	logic [47:0]        mac_q;
	logic [15:0]        tmo_q, ign_q;

	lmsm_pkg::fx_t cur;
	logic          load, fire, at_end;

	assign cur    = head.fx[idx_q];
	assign load   = !valid_q || m_ready;
	assign fire   = load && !empty;
	assign at_end = (idx_q == head.count - 2'd1);
	assign pop    = fire && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= !empty;
			if (fire) begin
				idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			kind_q      <= cur.kind;
			pstate_q    <= cur.pstate;
			rdy_q       <= cur.rdy;
			mac_q       <= (cur.kind == lmsm_pkg::FX_MAC) ? head.mac : '0;
			tmo_q       <= (cur.kind == lmsm_pkg::FX_START) ? head.tmo : '0;
			last_q      <= at_end;
			state_now_q <= head.state_now;
			ready_now_q <= head.ready_now;
			ign_q       <= head.ignored;
		end
	end

	assign m_valid = valid_q;
	assign last    = last_q;
	assign kind    = kind_q;
	assign data    = {ign_q, ready_now_q, state_now_q, tmo_q, mac_q, rdy_q, pstate_q};

endmodule

>>> design/link_match_state_machine_unit.sv
// ----------------------------------------------------------------------------
// link_match_state_machine_unit
// Link matching controller with an APB register port and item streams
// ----------------------------------------------------------------------------
// One event item is accepted per cycle while the two-entry internal queue has
// room. The mode machine updates at acceptance. The item's effects then leave
// one per cycle from the output register while the receiver is ready, one to
// three results per item. An accepted item is held in the queue and each
// result is registered in the output register. Registers: 0x0 mac_publish_enable,
// 0x4 detect_timeout_ms.
module link_match_state_machine_unit #(
	parameter int QUEUE_DEPTH = lmsm_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// apb
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// event items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // carrier_present, neighbor_mac, mac_present
	input  logic [2:0]  s_axis_tuser,  // action
	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [87:0] m_axis_tdata,  // published_state, ready_value, mac_out,
	                                   // timeout_out, state_now, ready_now, ignored_total
	output logic [2:0]  m_axis_tuser,  // effect_kind
	output logic        m_axis_tlast   // last_of_run
);

	logic            mac_en_q;
	logic [15:0]     tmo_cfg_q;
	logic            push, pop, q_full, q_empty;
	lmsm_pkg::plan_t push_plan, head;
	lmsm_pkg::fx_kind_t out_kind;
	logic [85:0]     out_data;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_en_q  <= 1'b0;
			tmo_cfg_q <= lmsm_pkg::TIMEOUT_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				lmsm_pkg::REG_MAC_EN:  mac_en_q  <= pwdata[0];
				lmsm_pkg::REG_TIMEOUT: tmo_cfg_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			lmsm_pkg::REG_MAC_EN:  prdata = {31'd0, mac_en_q};
			lmsm_pkg::REG_TIMEOUT: prdata = {16'd0, tmo_cfg_q};
			default:               prdata = '0;
		endcase
	end

	lmsm_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.s_valid            (s_axis_tvalid),
		.s_ready            (s_axis_tready),
		.action             (lmsm_pkg::act_t'(s_axis_tuser)),
		.carrier_present    (s_axis_tdata[0]),
		.neighbor_mac       (s_axis_tdata[48:1]),
		.mac_present        (s_axis_tdata[49]),
		.mac_publish_enable (mac_en_q),
		.detect_timeout_ms  (tmo_cfg_q),
		.q_full             (q_full),
		.push               (push),
		.push_plan          (push_plan)
	);

	lmsm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_plan (push_plan),
		.full      (q_full),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty)
	);

	lmsm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.empty   (q_empty),
		.pop     (pop),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.last    (m_axis_tlast),
		.kind    (out_kind),
		.data    (out_data)
	);

	assign m_axis_tuser = out_kind;
	assign m_axis_tdata = {2'b00, out_data};

endmodule
